FILE: rtl/core/ssdg_pkg.sv
`default_nettype none

package ssdg_pkg;

   // Precision of the angle path, the output rounding and the CORDIC length.
   localparam int ANGLE_BITS   = 16;
   localparam int OUT_BITS     = 16;
   localparam int CORDIC_ITERS = 16;

   localparam int ITER_W = $clog2(CORDIC_ITERS);

   // CORDIC vector components are Q2.30; the residual angle needs one more bit
   // of headroom than a quarter turn of 2^-32 turn units.
   localparam int CORDIC_W = 32;
   localparam int ZW       = 33;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

   // atan(2^-k) in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_THETA_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHI_START   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THETA_STEP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHI_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_H_RAY_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_V_RAY_COUNT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CLOCKWISE   = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;   // take the request, settle the shot indices
      logic              angle;     // form both angles, advance the scan, seed CORDIC
      logic              iter;      // one CORDIC micro-rotation on both lanes
      logic [ITER_W-1:0] iter_k;    // micro-rotation number
      logic              quad;      // undo the quadrant reduction
      logic              mul_x;     // sin phi * cos theta, round cos phi
      logic              mul_y;     // round x, sin phi * sin theta
      logic              load_out;  // move the finished shot to the output register
   } cmd_type;

   typedef struct packed {
      logic empty;                  // a ray count is zero
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/ssdg_ctrl.sv
`default_nettype none

module ssdg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output ssdg_pkg::cmd_type    cmd,
   input  ssdg_pkg::status_type status
);
   import ssdg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_ITER,
      ST_QUAD,
      ST_MUL_X,
      ST_MUL_Y,
      ST_FINISH
   } state_type;

   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   // The output register can take a new shot when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      cmd          = '0;
      cmd.iter_k   = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            cmd.angle = 1'b1;
            iter_in   = '0;
            state_in  = status.empty ? ST_FINISH : ST_ITER;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = ST_QUAD;
            end else begin
               iter_in = iter_ff + ITER_W'(1);
            end
         end
         ST_QUAD: begin
            cmd.quad = 1'b1;
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ssdg_datapath.sv
`default_nettype none

module ssdg_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ssdg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssdg_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_restart,
   input  ssdg_pkg::cmd_type                 cmd,
   output ssdg_pkg::status_type              status,
   output logic signed [15:0]                rsp_dir_x,
   output logic signed [15:0]                rsp_dir_y,
   output logic signed [15:0]                rsp_dir_z,
   output logic [15:0]                       rsp_h_index,
   output logic [15:0]                       rsp_v_index,
   output logic                              rsp_last_shot,
   output logic                              rsp_valid_res
);
   import ssdg_pkg::*;

   localparam int PW     = 2 * CORDIC_W;
   localparam int RND_SH = 61 - OUT_BITS;

   localparam logic signed [PW-1:0] RND_HALF = 64'sd1 <<< (RND_SH - 1);
   localparam logic signed [PW-1:0] OUT_MAX  = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
   localparam logic signed [PW-1:0] OUT_MIN  = -OUT_MAX - 64'sd1;
   localparam logic [PW-1:0]        OUT_MASK = (64'd1 << OUT_BITS) - 64'd1;
   localparam logic [31:0]          ANGLE_MASK =
      32'(~((64'd1 << (32 - ANGLE_BITS)) - 64'd1));

   // Q60 to Q1.(OUT_BITS-1): round half up, saturate, keep the field bits.
   function automatic logic [15:0] round_out(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      logic [PW-1:0]        m;
      r = (v + RND_HALF) >>> RND_SH;
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
      end
      m = r & OUT_MASK;
      return m[15:0];
   endfunction

   // Configuration registers.
   logic [15:0] theta_start_ff, phi_start_ff, theta_step_ff, phi_step_ff;
   logic [15:0] h_count_ff, v_count_ff;
   logic        clockwise_ff;

   // Scan position and the indices of the shot in flight.
   logic [15:0] h_counter_ff, h_counter_in, v_counter_ff, v_counter_in;
   logic [15:0] idx_h_ff, idx_h_in, idx_v_ff, idx_v_in;
   logic        empty_ff, empty_in, last_ff, last_in;

   // CORDIC lanes: index 0 is theta, index 1 is phi.
   logic signed [CORDIC_W-1:0] x_ff [2], x_in [2];
   logic signed [CORDIC_W-1:0] y_ff [2], y_in [2];
   logic signed [ZW-1:0]       z_ff [2], z_in [2];
   logic [1:0]                 q_ff [2], q_in [2];
   logic signed [CORDIC_W-1:0] cos_ff [2], cos_in [2];
   logic signed [CORDIC_W-1:0] sin_ff [2], sin_in [2];

   logic signed [PW-1:0] prod_ff, prod_in;
   logic [15:0]          res_x_ff, res_x_in, res_z_ff, res_z_in;

   logic [15:0] dir_x_ff, dir_y_ff, dir_z_ff, h_index_ff, v_index_ff;
   logic        last_shot_ff, valid_res_ff;

   // Scan bookkeeping.
   logic        empty_now, out_of_range, start_over;
   logic [16:0] v_inc, h_inc;
   logic        v_wrap, h_wrap;
   logic [15:0] t_mul, p_mul, t_sum, p_sum, t_ang;
   logic [31:0] t_q32, p_q32;

   always_comb begin
      empty_now    = (h_count_ff == 16'd0) || (v_count_ff == 16'd0);
      out_of_range = (h_counter_ff >= h_count_ff) || (v_counter_ff >= v_count_ff);
      start_over   = req_restart || empty_now || out_of_range;

      idx_h_in = idx_h_ff;
      idx_v_in = idx_v_ff;
      empty_in = empty_ff;
      if (cmd.capture) begin
         idx_h_in = start_over ? 16'd0 : h_counter_ff;
         idx_v_in = start_over ? 16'd0 : v_counter_ff;
         empty_in = empty_now;
      end

      v_inc  = {1'b0, idx_v_ff} + 17'd1;
      h_inc  = {1'b0, idx_h_ff} + 17'd1;
      v_wrap = (v_inc >= {1'b0, v_count_ff});
      h_wrap = (h_inc >= {1'b0, h_count_ff});

      h_counter_in = h_counter_ff;
      v_counter_in = v_counter_ff;
      last_in      = last_ff;
      if (cmd.angle) begin
         if (empty_ff) begin
            h_counter_in = 16'd0;
            v_counter_in = 16'd0;
         end else begin
            v_counter_in = v_wrap ? 16'd0 : v_inc[15:0];
            h_counter_in = !v_wrap ? idx_h_ff : (h_wrap ? 16'd0 : h_inc[15:0]);
         end
         last_in = (idx_h_ff == h_count_ff - 16'd1) && (idx_v_ff == v_count_ff - 16'd1);
      end

      // Grid angles, modulo one turn, then quantized to ANGLE_BITS.
      t_mul = idx_h_ff * theta_step_ff;
      p_mul = idx_v_ff * phi_step_ff;
      t_sum = theta_start_ff + t_mul;
      p_sum = phi_start_ff + p_mul;
      t_ang = clockwise_ff ? (16'd0 - t_sum) : t_sum;
      t_q32 = {t_ang, 16'h0000} & ANGLE_MASK;
      p_q32 = {p_sum, 16'h0000} & ANGLE_MASK;
   end

   // CORDIC rotation mode on both lanes, then quadrant restore.
   always_comb begin
      logic signed [CORDIC_W-1:0] dx, dy;
      logic signed [ZW-1:0]       da;
      for (int l = 0; l < 2; l++) begin
         x_in[l]   = x_ff[l];
         y_in[l]   = y_ff[l];
         z_in[l]   = z_ff[l];
         q_in[l]   = q_ff[l];
         cos_in[l] = cos_ff[l];
         sin_in[l] = sin_ff[l];
      end
      dx = '0;
      dy = '0;
      da = '0;
      if (cmd.angle) begin
         x_in[0] = CORDIC_GAIN;
         y_in[0] = '0;
         z_in[0] = {3'b000, t_q32[29:0]};
         q_in[0] = t_q32[31:30];
         x_in[1] = CORDIC_GAIN;
         y_in[1] = '0;
         z_in[1] = {3'b000, p_q32[29:0]};
         q_in[1] = p_q32[31:30];
      end
      if (cmd.iter) begin
         for (int l = 0; l < 2; l++) begin
            dx = y_ff[l] >>> cmd.iter_k;
            dy = x_ff[l] >>> cmd.iter_k;
            da = {1'b0, ATAN_TAB[5'(cmd.iter_k)]};
            if (!z_ff[l][ZW-1]) begin
               x_in[l] = x_ff[l] - dx;
               y_in[l] = y_ff[l] + dy;
               z_in[l] = z_ff[l] - da;
            end else begin
               x_in[l] = x_ff[l] + dx;
               y_in[l] = y_ff[l] - dy;
               z_in[l] = z_ff[l] + da;
            end
         end
      end
      if (cmd.quad) begin
         for (int l = 0; l < 2; l++) begin
            case (q_ff[l])
               2'd0: begin
                  cos_in[l] = x_ff[l];
                  sin_in[l] = y_ff[l];
               end
               2'd1: begin
                  cos_in[l] = -y_ff[l];
                  sin_in[l] = x_ff[l];
               end
               2'd2: begin
                  cos_in[l] = -x_ff[l];
                  sin_in[l] = -y_ff[l];
               end
               default: begin
                  cos_in[l] = y_ff[l];
                  sin_in[l] = -x_ff[l];
               end
            endcase
         end
      end
   end

   // One multiplier, used for x and then for y; z is cos phi scaled to Q60.
   always_comb begin
      prod_in  = prod_ff;
      res_x_in = res_x_ff;
      res_z_in = res_z_ff;
      if (cmd.mul_x) begin
         prod_in  = sin_ff[1] * cos_ff[0];
         res_z_in = round_out({{2{cos_ff[1][CORDIC_W-1]}}, cos_ff[1], 30'b0});
      end
      if (cmd.mul_y) begin
         prod_in  = sin_ff[1] * sin_ff[0];
         res_x_in = round_out(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         theta_start_ff <= '0;
         phi_start_ff   <= '0;
         theta_step_ff  <= '0;
         phi_step_ff    <= '0;
         h_count_ff     <= '0;
         v_count_ff     <= '0;
         clockwise_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_THETA_START: theta_start_ff <= csr_data;
            REG_PHI_START:   phi_start_ff   <= csr_data;
            REG_THETA_STEP:  theta_step_ff  <= csr_data;
            REG_PHI_STEP:    phi_step_ff    <= csr_data;
            REG_H_RAY_COUNT: h_count_ff     <= csr_data;
            REG_V_RAY_COUNT: v_count_ff     <= csr_data;
            REG_CLOCKWISE:   clockwise_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_counter_ff <= '0;
         v_counter_ff <= '0;
      end else begin
         h_counter_ff <= h_counter_in;
         v_counter_ff <= v_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_h_ff <= idx_h_in;
      idx_v_ff <= idx_v_in;
      empty_ff <= empty_in;
      last_ff  <= last_in;
      for (int l = 0; l < 2; l++) begin
         x_ff[l]   <= x_in[l];
         y_ff[l]   <= y_in[l];
         z_ff[l]   <= z_in[l];
         q_ff[l]   <= q_in[l];
         cos_ff[l] <= cos_in[l];
         sin_ff[l] <= sin_in[l];
      end
      prod_ff  <= prod_in;
      res_x_ff <= res_x_in;
      res_z_ff <= res_z_in;
   end

   // Output register; only loaded when the result side can take a new shot.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         dir_x_ff     <= empty_ff ? 16'd0 : res_x_ff;
         dir_y_ff     <= empty_ff ? 16'd0 : round_out(prod_ff);
         dir_z_ff     <= empty_ff ? 16'd0 : res_z_ff;
         h_index_ff   <= empty_ff ? 16'd0 : idx_h_ff;
         v_index_ff   <= empty_ff ? 16'd0 : idx_v_ff;
         last_shot_ff <= !empty_ff && last_ff;
         valid_res_ff <= !empty_ff;
      end
   end

   assign status.empty  = empty_ff;
   assign rsp_dir_x     = $signed(dir_x_ff);
   assign rsp_dir_y     = $signed(dir_y_ff);
   assign rsp_dir_z     = $signed(dir_z_ff);
   assign rsp_h_index   = h_index_ff;
   assign rsp_v_index   = v_index_ff;
   assign rsp_last_shot = last_shot_ff;
   assign rsp_valid_res = valid_res_ff;

endmodule

`default_nettype wire

FILE: rtl/core/spherical_scan_direction_generator.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_restart
// rsp       out        rsp_valid / rsp_stall  rsp_dir_x/y/z, rsp_h_index, rsp_v_index,
//                                             rsp_last_shot, rsp_valid_res
// csr       in         csr_wr_en              csr_index, csr_data
//
// A request passes from acceptance to its result in the output register in order:
// settling the indices, forming the angles, the CORDIC_ITERS micro-rotations of the
// shared two-lane CORDIC loop, the quadrant restore, two products on the single
// multiplier and the output load. An empty pattern skips the CORDIC and multiplier.
// Reset is synchronous and restores the configuration defaults and the first shot.
// The output register holds a result while rsp_stall is high, and a new request is
// taken while that result waits; the next result waits in the datapath until the
// output register is free.

module spherical_scan_direction_generator (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes.
   input  logic                              csr_wr_en,
   input  logic [ssdg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssdg_pkg::CSR_DATA_W-1:0]   csr_data,
   // Request channel: one request asks for the next shot of the scan.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   // Result channel: the direction of that shot.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_dir_x,
   output logic signed [15:0]                rsp_dir_y,
   output logic signed [15:0]                rsp_dir_z,
   output logic [15:0]                       rsp_h_index,
   output logic [15:0]                       rsp_v_index,
   output logic                              rsp_last_shot,
   output logic                              rsp_valid_res
);
   import ssdg_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences each request through the datapath and owns both
   // handshakes; it takes a request only in its idle state.
   ssdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the configuration, the scan counters, the two CORDIC lanes
   // (azimuth and polar angle run side by side), the product stage and the output
   // register.
   ssdg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_restart   (req_restart),
      .cmd           (cmd),
      .status        (status),
      .rsp_dir_x     (rsp_dir_x),
      .rsp_dir_y     (rsp_dir_y),
      .rsp_dir_z     (rsp_dir_z),
      .rsp_h_index   (rsp_h_index),
      .rsp_v_index   (rsp_v_index),
      .rsp_last_shot (rsp_last_shot),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

`default_nettype wire
